>>> rtl/core/drr_pkg.sv
// Package for the drop-oldest record ring: field widths, command and status
// codes, and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package drr_pkg;

   localparam int CMD_W    = 2;
   localparam int DATA_W   = 8;
   localparam int LEN_W    = 10;
   localparam int OFF_W    = 10;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 11;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DROP   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] RSP_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_TOO_LARGE  = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_EMPTY      = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_BAD_OFFSET = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_UNEXPECTED = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RD_WAIT,
      ST_EVICT,
      ST_HDR_ADDR,
      ST_HDR_CAP,
      ST_WR_HDR,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

>>> rtl/core/drr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module drr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/core/drop_oldest_record_ring_core.sv
// Byte ring of variable-length records with drop-oldest append.
// Uses drr_pkg and drr_ram (the byte store).
//
// One command is taken at a time: start is taken while busy is low, and the
// result appears for exactly one cycle with rsp_valid high; the receiver
// cannot stall it. All byte traffic goes through one byte RAM with one write
// port and one registered read port, and one shared pointer/size unit retires
// records. Every command passes through DECIDE and DONE. A payload byte, a
// drop of the last record, a clear and any error go straight from DECIDE to
// DONE; a read adds RD_WAIT; a drop with records left reads back the header
// of the new oldest record; a new record passes through EVICT, which drops
// records to make room, then writes its header in WR_HDR (the header of each
// new oldest record is read back one byte at a time, via HDR_ADDR and HDR_CAP).
`timescale 1ns / 1ps
`default_nettype none
module drop_oldest_record_ring_core #(
   parameter int RING_BYTES   = 1024,
   parameter int HEADER_BYTES = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [drr_pkg::CMD_W-1:0]     req_command,
   input  wire logic [drr_pkg::DATA_W-1:0]    req_data_byte,
   input  wire logic                          req_first,
   input  wire logic [drr_pkg::LEN_W-1:0]     req_record_length,
   input  wire logic [drr_pkg::OFF_W-1:0]     req_offset,
   output logic                               rsp_valid,
   output logic      [drr_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [drr_pkg::DATA_W-1:0]    rsp_read_data,
   output logic      [drr_pkg::COUNT_W-1:0]   rsp_record_count,
   output logic      [drr_pkg::LEN_W-1:0]     rsp_oldest_size,
   output logic      [drr_pkg::COUNT_W-1:0]   rsp_free_bytes,
   output logic      [drr_pkg::COUNT_W-1:0]   rsp_dropped
);

   localparam int PTR_W    = $clog2(RING_BYTES);
   localparam int CNT_W    = PTR_W + 1;
   localparam int SUM_W    = PTR_W + 1;
   localparam int NEED_W   = drr_pkg::LEN_W + 1;
   localparam int HDR_BITS = 8 * HEADER_BYTES;
   localparam int HIDX_W   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

   function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] ring;
      ring = SUM_W'(RING_BYTES);
      return (x >= ring) ? PTR_W'(x - ring) : PTR_W'(x);
   endfunction

   drr_pkg::state_type state_ff, state_in;

   logic [drr_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [drr_pkg::DATA_W-1:0]   data_ff, data_in;
   logic                         first_ff, first_in;
   logic [drr_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [drr_pkg::OFF_W-1:0]    off_ff, off_in;
   logic [drr_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [drr_pkg::DATA_W-1:0]   rdata_ff, rdata_in;
   logic [CNT_W-1:0]             dropped_ff, dropped_in;
   logic [HIDX_W-1:0]            hidx_ff, hidx_in;

   logic [PTR_W-1:0]             rp_ff, rp_in;
   logic [PTR_W-1:0]             wp_ff, wp_in;
   logic [CNT_W-1:0]             used_ff, used_in;
   logic [CNT_W-1:0]             held_ff, held_in;
   logic [drr_pkg::LEN_W-1:0]    pending_ff, pending_in;
   logic [drr_pkg::LEN_W-1:0]    oldest_ff, oldest_in;

   logic [NEED_W-1:0]            need;
   logic                         too_large;
   logic                         evict_needed;
   logic                         hidx_last;
   logic [31:0]                  drop_full;
   logic [CNT_W-1:0]             drop_sz;
   logic [PTR_W-1:0]             drop_rp;
   logic [CNT_W-1:0]             drop_used;
   logic [drr_pkg::LEN_W-1:0]    drop_pending;
   logic [PTR_W-1:0]             read_addr;
   logic [PTR_W-1:0]             payload_addr;
   logic [drr_pkg::DATA_W-1:0]   hdr_byte;

   logic                         ram_we;
   logic [PTR_W-1:0]             ram_waddr;
   logic [drr_pkg::DATA_W-1:0]   ram_wdata;
   logic [PTR_W-1:0]             ram_raddr;
   logic [drr_pkg::DATA_W-1:0]   ram_q;

   drr_ram #(
      .WIDTH (drr_pkg::DATA_W),
      .DEPTH (RING_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // shared size and pointer unit
   always_comb begin
      need         = NEED_W'(len_ff) + NEED_W'(HEADER_BYTES);
      too_large    = (32'(need) > 32'(RING_BYTES)) || ((32'(len_ff) >> HDR_BITS) != 32'd0);
      evict_needed = ((32'(used_ff) + 32'(need)) > 32'(RING_BYTES)) && (held_ff != '0);
      hidx_last    = (hidx_ff == HIDX_W'(HEADER_BYTES - 1));
      drop_full    = 32'(oldest_ff) + 32'(HEADER_BYTES);
      drop_sz      = ((drop_full > 32'(used_ff)) || (held_ff == CNT_W'(1)))
                     ? used_ff : CNT_W'(drop_full);
      drop_rp      = (held_ff == CNT_W'(1)) ? wp_ff
                     : wrap(SUM_W'(rp_ff) + SUM_W'(drop_sz));
      drop_used    = used_ff - drop_sz;
      drop_pending = (held_ff == CNT_W'(1)) ? '0 : pending_ff;
      read_addr    = wrap(SUM_W'(rp_ff) + SUM_W'(HEADER_BYTES) + SUM_W'(off_ff));
      payload_addr = wrap(SUM_W'(wp_ff) + SUM_W'(RING_BYTES) - SUM_W'(pending_ff));
      hdr_byte     = drr_pkg::DATA_W'(32'(len_ff) >> {hidx_ff, 3'b000});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drr_pkg::ST_IDLE: begin
            if (start) begin
               state_in = drr_pkg::ST_DECIDE;
            end
         end
         drr_pkg::ST_DECIDE: begin
            unique case (cmd_ff)
               drr_pkg::CMD_APPEND: begin
                  state_in = (first_ff && !too_large) ? drr_pkg::ST_EVICT : drr_pkg::ST_DONE;
               end
               drr_pkg::CMD_READ: begin
                  state_in = ((held_ff != '0) && (off_ff < oldest_ff))
                             ? drr_pkg::ST_RD_WAIT : drr_pkg::ST_DONE;
               end
               drr_pkg::CMD_DROP: begin
                  state_in = (held_ff > CNT_W'(1)) ? drr_pkg::ST_HDR_ADDR : drr_pkg::ST_DONE;
               end
               drr_pkg::CMD_CLEAR: begin
                  state_in = drr_pkg::ST_DONE;
               end
               default: begin
                  state_in = drr_pkg::ST_DONE;
               end
            endcase
         end
         drr_pkg::ST_RD_WAIT: begin
            state_in = drr_pkg::ST_DONE;
         end
         drr_pkg::ST_EVICT: begin
            if (evict_needed) begin
               state_in = (held_ff > CNT_W'(1)) ? drr_pkg::ST_HDR_ADDR : drr_pkg::ST_EVICT;
            end else begin
               state_in = drr_pkg::ST_WR_HDR;
            end
         end
         drr_pkg::ST_HDR_ADDR: begin
            state_in = drr_pkg::ST_HDR_CAP;
         end
         drr_pkg::ST_HDR_CAP: begin
            if (hidx_last) begin
               state_in = (cmd_ff == drr_pkg::CMD_APPEND) ? drr_pkg::ST_EVICT : drr_pkg::ST_DONE;
            end else begin
               state_in = drr_pkg::ST_HDR_ADDR;
            end
         end
         drr_pkg::ST_WR_HDR: begin
            if (hidx_last) begin
               state_in = drr_pkg::ST_DONE;
            end
         end
         drr_pkg::ST_DONE: begin
            state_in = drr_pkg::ST_IDLE;
         end
         default: begin
            state_in = drr_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      cmd_in     = cmd_ff;
      data_in    = data_ff;
      first_in   = first_ff;
      len_in     = len_ff;
      off_in     = off_ff;
      status_in  = status_ff;
      rdata_in   = rdata_ff;
      dropped_in = dropped_ff;
      hidx_in    = hidx_ff;
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      used_in    = used_ff;
      held_in    = held_ff;
      pending_in = pending_ff;
      oldest_in  = oldest_ff;
      unique case (state_ff)
         drr_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in     = req_command;
               data_in    = req_data_byte;
               first_in   = req_first;
               len_in     = req_record_length;
               off_in     = req_offset;
               status_in  = drr_pkg::RSP_OK;
               rdata_in   = '0;
               dropped_in = '0;
            end
         end
         drr_pkg::ST_DECIDE: begin
            hidx_in = '0;
            unique case (cmd_ff)
               drr_pkg::CMD_APPEND: begin
                  if (first_ff) begin
                     if (too_large) begin
                        status_in = drr_pkg::RSP_TOO_LARGE;
                     end
                  end else if (pending_ff == '0) begin
                     status_in = drr_pkg::RSP_UNEXPECTED;
                  end else begin
                     pending_in = pending_ff - drr_pkg::LEN_W'(1);
                  end
               end
               drr_pkg::CMD_READ: begin
                  if (held_ff == '0) begin
                     status_in = drr_pkg::RSP_EMPTY;
                  end else if (off_ff >= oldest_ff) begin
                     status_in = drr_pkg::RSP_BAD_OFFSET;
                  end
               end
               drr_pkg::CMD_DROP: begin
                  if (held_ff == '0) begin
                     status_in = drr_pkg::RSP_EMPTY;
                  end else begin
                     rp_in      = drop_rp;
                     used_in    = drop_used;
                     held_in    = held_ff - CNT_W'(1);
                     pending_in = drop_pending;
                     oldest_in  = '0;
                  end
               end
               drr_pkg::CMD_CLEAR: begin
                  rp_in      = '0;
                  wp_in      = '0;
                  used_in    = '0;
                  held_in    = '0;
                  pending_in = '0;
                  oldest_in  = '0;
               end
               default: begin
                  status_in = drr_pkg::RSP_OK;
               end
            endcase
         end
         drr_pkg::ST_RD_WAIT: begin
            rdata_in = ram_q;
         end
         drr_pkg::ST_EVICT: begin
            hidx_in = '0;
            if (evict_needed) begin
               rp_in      = drop_rp;
               used_in    = drop_used;
               held_in    = held_ff - CNT_W'(1);
               pending_in = drop_pending;
               oldest_in  = '0;
               dropped_in = dropped_ff + CNT_W'(1);
            end
         end
         drr_pkg::ST_HDR_ADDR: begin
            hidx_in = hidx_ff;
         end
         drr_pkg::ST_HDR_CAP: begin
            for (int b = 0; b < drr_pkg::LEN_W; b++) begin
               if ((b / 8) == int'(hidx_ff)) begin
                  oldest_in[b] = ram_q[b % 8];
               end
            end
            hidx_in = hidx_ff + HIDX_W'(1);
         end
         drr_pkg::ST_WR_HDR: begin
            hidx_in = hidx_ff + HIDX_W'(1);
            if (hidx_last) begin
               if (held_ff == '0) begin
                  rp_in     = wp_ff;
                  oldest_in = len_ff;
               end
               wp_in      = wrap(SUM_W'(wp_ff) + SUM_W'(need));
               used_in    = used_ff + CNT_W'(need);
               held_in    = held_ff + CNT_W'(1);
               pending_in = len_ff;
            end
         end
         drr_pkg::ST_DONE: begin
            hidx_in = hidx_ff;
         end
         default: begin
            hidx_in = hidx_ff;
         end
      endcase
   end

   // outputs and byte store control
   always_comb begin
      busy      = (state_ff != drr_pkg::ST_IDLE);
      rsp_valid = (state_ff == drr_pkg::ST_DONE);
      ram_we    = 1'b0;
      ram_waddr = payload_addr;
      ram_wdata = data_ff;
      ram_raddr = read_addr;
      unique case (state_ff)
         drr_pkg::ST_DECIDE: begin
            if ((cmd_ff == drr_pkg::CMD_APPEND) && !first_ff && (pending_ff != '0)) begin
               ram_we = 1'b1;
            end
         end
         drr_pkg::ST_HDR_ADDR: begin
            ram_raddr = wrap(SUM_W'(rp_ff) + SUM_W'(hidx_ff));
         end
         drr_pkg::ST_WR_HDR: begin
            ram_we    = 1'b1;
            ram_waddr = wrap(SUM_W'(wp_ff) + SUM_W'(hidx_ff));
            ram_wdata = hdr_byte;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= drr_pkg::ST_IDLE;
         rp_ff      <= '0;
         wp_ff      <= '0;
         used_ff    <= '0;
         held_ff    <= '0;
         pending_ff <= '0;
         oldest_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         rp_ff      <= rp_in;
         wp_ff      <= wp_in;
         used_ff    <= used_in;
         held_ff    <= held_in;
         pending_ff <= pending_in;
         oldest_ff  <= oldest_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      data_ff    <= data_in;
      first_ff   <= first_in;
      len_ff     <= len_in;
      off_ff     <= off_in;
      status_ff  <= status_in;
      rdata_ff   <= rdata_in;
      dropped_ff <= dropped_in;
      hidx_ff    <= hidx_in;
   end

   assign rsp_status       = status_ff;
   assign rsp_read_data    = rdata_ff;
   assign rsp_record_count = drr_pkg::COUNT_W'(held_ff);
   assign rsp_oldest_size  = oldest_ff;
   assign rsp_free_bytes   = drr_pkg::COUNT_W'(CNT_W'(RING_BYTES) - used_ff);
   assign rsp_dropped      = drr_pkg::COUNT_W'(dropped_ff);

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == drr_pkg::ST_IDLE) && (held_ff == '0))
      |-> ((used_ff == '0) && (pending_ff == '0) && (oldest_ff == '0)))
      else $error("empty ring holds stale space or size");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      (used_ff <= CNT_W'(RING_BYTES)))
      else $error("used bytes exceed ring size");

   a_ptr_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == drr_pkg::ST_IDLE) |-> (wrap(SUM_W'(rp_ff) + SUM_W'(used_ff)) == wp_ff))
      else $error("pointers disagree with used bytes");

   a_ready_after_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("not ready after result beat");

endmodule
`default_nettype wire

>>> sim/drop_oldest_record_ring_core_tb.sv
// Testbench for drop_oldest_record_ring_core: a table of directed commands, then random
// record traffic, each result checked against the table or an in-bench model of the ring.
// Depends on drr_pkg and the core RTL only.
`timescale 1ns / 1ps
module drop_oldest_record_ring_core_tb;

   localparam int RING   = 1024;
   localparam int HDR    = 2;
   localparam int PERIOD = 12;

   typedef struct {
      logic [drr_pkg::CMD_W-1:0]  cmd;
      logic [drr_pkg::DATA_W-1:0] data;
      logic                       first;
      logic [drr_pkg::LEN_W-1:0]  len;
      logic [drr_pkg::OFF_W-1:0]  off;
   } ring_cmd_type;

   typedef struct {
      logic [drr_pkg::STATUS_W-1:0] status;
      logic [drr_pkg::DATA_W-1:0]   rdata;
      logic [drr_pkg::COUNT_W-1:0]  count;
      logic [drr_pkg::LEN_W-1:0]    oldest;
      logic [drr_pkg::COUNT_W-1:0]  free;
      logic [drr_pkg::COUNT_W-1:0]  dropped;
   } ring_rsp_type;

   typedef struct {
      ring_cmd_type c;
      bit           typed;
      ring_rsp_type want;
   } plan_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic [drr_pkg::CMD_W-1:0]    req_command = '0;
   logic [drr_pkg::DATA_W-1:0]   req_data_byte = '0;
   logic                         req_first = 1'b0;
   logic [drr_pkg::LEN_W-1:0]    req_record_length = '0;
   logic [drr_pkg::OFF_W-1:0]    req_offset = '0;
   logic                         busy;
   logic                         rsp_valid;
   logic [drr_pkg::STATUS_W-1:0] rsp_status;
   logic [drr_pkg::DATA_W-1:0]   rsp_read_data;
   logic [drr_pkg::COUNT_W-1:0]  rsp_record_count;
   logic [drr_pkg::LEN_W-1:0]    rsp_oldest_size;
   logic [drr_pkg::COUNT_W-1:0]  rsp_free_bytes;
   logic [drr_pkg::COUNT_W-1:0]  rsp_dropped;

   bit [7:0]  ring_mem [RING];
   bit        mem_set  [RING];
   int        rd_ptr = 0;
   int        wr_ptr = 0;
   int        used_bytes = 0;
   int        held_recs = 0;
   int        due_bytes = 0;

   ring_rsp_type rsp_due [$];
   plan_row_type plan [$];
   int           fails = 0;
   int           idle_pct = 0;
   int           idle_plan [4] = '{0, 56, 18, 0};

   drop_oldest_record_ring_core #(
      .RING_BYTES(RING),
      .HEADER_BYTES(HDR)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_data_byte(req_data_byte),
      .req_first(req_first),
      .req_record_length(req_record_length),
      .req_offset(req_offset),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_read_data(rsp_read_data),
      .rsp_record_count(rsp_record_count),
      .rsp_oldest_size(rsp_oldest_size),
      .rsp_free_bytes(rsp_free_bytes),
      .rsp_dropped(rsp_dropped)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic int header_len(int pos);
      int v = 0;
      for (int i = 0; i < HDR; i++) v |= int'(ring_mem[(pos + i) % RING]) << (8 * i);
      return v;
   endfunction

   function automatic int oldest_len();
      return (held_recs != 0) ? header_len(rd_ptr) : 0;
   endfunction

   function automatic void retire_oldest();
      int sz;
      sz = header_len(rd_ptr) + HDR;
      if (sz > used_bytes || held_recs == 1) sz = used_bytes;
      rd_ptr = (rd_ptr + sz) % RING;
      used_bytes -= sz;
      held_recs--;
      if (held_recs == 0) begin
         used_bytes = 0;
         due_bytes  = 0;
         rd_ptr     = wr_ptr;
      end
   endfunction

   function automatic ring_rsp_type ring_step(ring_cmd_type c);
      ring_rsp_type r;
      int need, pos, lost;
      r.status = drr_pkg::RSP_OK;
      r.rdata  = '0;
      lost     = 0;
      case (c.cmd)
         drr_pkg::CMD_APPEND: begin
            if (c.first) begin
               need = int'(c.len) + HDR;
               if (need > RING || (int'(c.len) >> (8 * HDR)) != 0) begin
                  r.status = drr_pkg::RSP_TOO_LARGE;
               end else begin
                  while (RING - used_bytes < need && held_recs > 0) begin
                     retire_oldest();
                     lost++;
                  end
                  for (int i = 0; i < HDR; i++) begin
                     ring_mem[(wr_ptr + i) % RING] = 8'(int'(c.len) >> (8 * i));
                     mem_set[(wr_ptr + i) % RING]  = 1'b1;
                  end
                  if (held_recs == 0) rd_ptr = wr_ptr;
                  wr_ptr = (wr_ptr + need) % RING;
                  used_bytes += need;
                  held_recs++;
                  due_bytes = int'(c.len);
               end
            end else if (due_bytes == 0) begin
               r.status = drr_pkg::RSP_UNEXPECTED;
            end else begin
               pos = (wr_ptr + RING - due_bytes) % RING;
               ring_mem[pos] = c.data;
               mem_set[pos]  = 1'b1;
               due_bytes--;
            end
         end
         drr_pkg::CMD_READ: begin
            if (held_recs == 0) r.status = drr_pkg::RSP_EMPTY;
            else if (int'(c.off) >= oldest_len()) r.status = drr_pkg::RSP_BAD_OFFSET;
            else r.rdata = ring_mem[(rd_ptr + HDR + int'(c.off)) % RING];
         end
         drr_pkg::CMD_DROP: begin
            if (held_recs == 0) r.status = drr_pkg::RSP_EMPTY;
            else retire_oldest();
         end
         default: begin
            rd_ptr     = 0;
            wr_ptr     = 0;
            used_bytes = 0;
            held_recs  = 0;
            due_bytes  = 0;
         end
      endcase
      r.count   = drr_pkg::COUNT_W'(held_recs);
      r.oldest  = drr_pkg::LEN_W'(oldest_len());
      r.free    = drr_pkg::COUNT_W'(RING - used_bytes);
      r.dropped = drr_pkg::COUNT_W'(lost);
      return r;
   endfunction

   // mostly well-formed records with random payload; reads never touch unwritten bytes
   function automatic ring_cmd_type next_beat();
      ring_cmd_type c;
      int roll, olen, pos;
      c.cmd   = drr_pkg::CMD_APPEND;
      c.data  = 8'($urandom);
      c.first = 1'($urandom);
      c.len   = 10'($urandom);
      c.off   = 10'($urandom);
      roll = $urandom_range(99);
      if (due_bytes > 0 && roll < 80) begin
         c.first = 1'b0;
      end else begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            c.first = 1'b1;
            roll = $urandom_range(99);
            if (roll < 75) c.len = 10'($urandom_range(12));
            else if (roll < 93) c.len = 10'($urandom_range(100, 13));
            else if (roll < 99) c.len = 10'($urandom_range(1022, 101));
            else c.len = 10'd1023;
         end else if (roll < 70) begin
            c.cmd = drr_pkg::CMD_READ;
         end else if (roll < 85) begin
            c.cmd = drr_pkg::CMD_DROP;
         end else if (roll < 88) begin
            c.cmd = drr_pkg::CMD_CLEAR;
         end else begin
            c.first = 1'b0;
         end
      end
      olen = oldest_len();
      if (c.cmd == drr_pkg::CMD_READ && held_recs != 0) begin
         if (olen != 0 && $urandom_range(3) != 0) c.off = 10'($urandom_range(olen - 1));
         pos = (rd_ptr + HDR + int'(c.off)) % RING;
         if (int'(c.off) < olen && !mem_set[pos]) c.off = 10'(olen);
      end
      return c;
   endfunction

   task automatic row(logic [drr_pkg::CMD_W-1:0] cmd, logic [drr_pkg::DATA_W-1:0] data,
                      logic first, logic [drr_pkg::LEN_W-1:0] len,
                      logic [drr_pkg::OFF_W-1:0] off, bit typed = 1'b0,
                      logic [drr_pkg::STATUS_W-1:0] st = drr_pkg::RSP_OK, int count = 0,
                      int oldest = 0, int free = RING, int lost = 0);
      plan_row_type p;
      p.c.cmd        = cmd;
      p.c.data       = data;
      p.c.first      = first;
      p.c.len        = len;
      p.c.off        = off;
      p.typed        = typed;
      p.want.status  = st;
      p.want.rdata   = '0;
      p.want.count   = drr_pkg::COUNT_W'(count);
      p.want.oldest  = drr_pkg::LEN_W'(oldest);
      p.want.free    = drr_pkg::COUNT_W'(free);
      p.want.dropped = drr_pkg::COUNT_W'(lost);
      plan.push_back(p);
   endtask

   task automatic issue(ring_cmd_type c, bit typed, ring_rsp_type want);
      ring_rsp_type p;
      start             <= 1'b1;
      req_command       <= c.cmd;
      req_data_byte     <= c.data;
      req_first         <= c.first;
      req_record_length <= c.len;
      req_offset        <= c.off;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = ring_step(c);
      rsp_due.push_back(typed ? want : p);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      ring_rsp_type e;
      if (!reset && rsp_valid === 1'b1) begin
         if (rsp_due.size() == 0) begin
            $error("result beat with no command outstanding");
            fails++;
         end else begin
            e = rsp_due.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_status);
               fails++;
            end
            if (rsp_read_data !== e.rdata) begin
               $error("read_data: expected %0d, actual %0d", e.rdata, rsp_read_data);
               fails++;
            end
            if (rsp_record_count !== e.count) begin
               $error("record_count: expected %0d, actual %0d", e.count, rsp_record_count);
               fails++;
            end
            if (rsp_oldest_size !== e.oldest) begin
               $error("oldest_size: expected %0d, actual %0d", e.oldest, rsp_oldest_size);
               fails++;
            end
            if (rsp_free_bytes !== e.free) begin
               $error("free_bytes: expected %0d, actual %0d", e.free, rsp_free_bytes);
               fails++;
            end
            if (rsp_dropped !== e.dropped) begin
               $error("dropped: expected %0d, actual %0d", e.dropped, rsp_dropped);
               fails++;
            end
         end
      end
   end

   initial begin
      ring_rsp_type blank;
      blank = '{default: '0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      row(drr_pkg::CMD_READ, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1,
          drr_pkg::RSP_EMPTY, 0, 0, 1024, 0);
      row(drr_pkg::CMD_DROP, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1,
          drr_pkg::RSP_EMPTY, 0, 0, 1024, 0);
      row(drr_pkg::CMD_APPEND, 8'h5A, 1'b0, 10'd0, 10'd0, 1'b1,
          drr_pkg::RSP_UNEXPECTED, 0, 0, 1024, 0);
      row(drr_pkg::CMD_APPEND, 8'h00, 1'b1, 10'd1023, 10'd0, 1'b1,
          drr_pkg::RSP_TOO_LARGE, 0, 0, 1024, 0);
      row(drr_pkg::CMD_APPEND, 8'hFF, 1'b1, 10'd0, 10'd0, 1'b1,
          drr_pkg::RSP_OK, 1, 0, 1022, 0);
      row(drr_pkg::CMD_READ, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1,
          drr_pkg::RSP_BAD_OFFSET, 1, 0, 1022, 0);
      row(drr_pkg::CMD_APPEND, 8'hFF, 1'b0, 10'd0, 10'd0, 1'b1,
          drr_pkg::RSP_UNEXPECTED, 1, 0, 1022, 0);
      row(drr_pkg::CMD_APPEND, 8'h00, 1'b1, 10'd3,    10'd0);
      row(drr_pkg::CMD_APPEND, 8'h00, 1'b0, 10'd0,    10'd0);
      row(drr_pkg::CMD_APPEND, 8'hFF, 1'b0, 10'd1023, 10'd1023);
      row(drr_pkg::CMD_APPEND, 8'hA5, 1'b0, 10'd0,    10'd0);
      row(drr_pkg::CMD_DROP,   8'h00, 1'b0, 10'd0,    10'd0);
      row(drr_pkg::CMD_READ,   8'h00, 1'b0, 10'd0,    10'd0);
      row(drr_pkg::CMD_READ,   8'h00, 1'b1, 10'd1023, 10'd2);
      row(drr_pkg::CMD_READ,   8'h00, 1'b0, 10'd0,    10'd3);
      row(drr_pkg::CMD_READ,   8'hFF, 1'b0, 10'd0,    10'd1023);
      row(drr_pkg::CMD_APPEND, 8'h00, 1'b1, 10'd5,    10'd0);
      row(drr_pkg::CMD_APPEND, 8'h5A, 1'b0, 10'd0,    10'd0);
      row(drr_pkg::CMD_APPEND, 8'h00, 1'b1, 10'd1,    10'd0);
      row(drr_pkg::CMD_APPEND, 8'h81, 1'b0, 10'd0,    10'd0);
      row(drr_pkg::CMD_CLEAR, 8'hFF, 1'b1, 10'd1023, 10'd1023, 1'b1,
          drr_pkg::RSP_OK, 0, 0, 1024, 0);
      row(drr_pkg::CMD_APPEND, 8'h00, 1'b1, 10'd1022, 10'd0, 1'b1,
          drr_pkg::RSP_OK, 1, 1022, 0, 0);
      row(drr_pkg::CMD_APPEND, 8'h00, 1'b1, 10'd0, 10'd0, 1'b1,
          drr_pkg::RSP_OK, 1, 0, 1022, 1);
      row(drr_pkg::CMD_APPEND, 8'h00, 1'b1, 10'd4,    10'd0);
      row(drr_pkg::CMD_DROP,   8'h00, 1'b0, 10'd0,    10'd0);
      row(drr_pkg::CMD_DROP, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1,
          drr_pkg::RSP_OK, 0, 0, 1024, 0);
      row(drr_pkg::CMD_APPEND, 8'h3C, 1'b0, 10'd0, 10'd0, 1'b1,
          drr_pkg::RSP_UNEXPECTED, 0, 0, 1024, 0);

      foreach (plan[i]) issue(plan[i].c, plan[i].typed, plan[i].want);

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_plan[ph];
         repeat (225) issue(next_beat(), 1'b0, blank);
      end

      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(PERIOD * 400_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
